>>> rtl/olps_pkg.sv
// ----------------------------------------------------------------------------
// olps_pkg: shared types and constants for the open-loop pitch search
// Sample format, lag width, register indexes and reset values, and the
// beat format carried from the front queue to the search engine.
// ----------------------------------------------------------------------------
package olps_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int LAG_W         = 9;
  localparam int MAX_FRAME_DEF = 512;
  localparam int QUEUE_DEPTH   = 4;
  localparam int CFG_IDX_W     = 1;

  localparam logic [LAG_W-1:0] MIN_LAG_RESET = 9'd20;
  localparam logic [LAG_W-1:0] MAX_LAG_RESET = 9'd143;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LAG = 1'b0,
    REG_MAX_LAG = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } olps_beat_t;

endpackage

>>> rtl/open_loop_pitch_search.sv
// ----------------------------------------------------------------------------
// open_loop_pitch_search: normalized autocorrelation pitch estimator
// Collects a frame of residual samples and returns the lag with the highest
// normalized autocorrelation between min_lag and max_lag.
// ----------------------------------------------------------------------------
// Feed one signed sample per beat and mark the final sample of the frame
// with last; one pitch_lag beat comes back per frame, none for other beats.
// Samples move at one per cycle through a four-beat queue into a
// MAX_FRAME-entry store, so input keeps flowing while the previous frame is
// searched until the queue fills. Samples past MAX_FRAME in a frame are
// dropped. The search then walks lags L from min_lag up to max_lag, stopping
// before the frame length N. Each lag's cross and energy sums are formed in a
// single multiply-accumulate set fed by the two read ports of the store;
// a lag with nonzero energies that its sign does not already rule out then
// has its squared cross term and energy product formed, and when it has
// to be ranked against the lag held so far, its two cross products, both on a
// pair of serial shift-add multipliers. Ranking is exact: xy^2 * xx' * yy'
// against xy'^2 * xx * yy with the signs handled, so no root or divide is
// needed. Lags with a zero energy are skipped, ties keep the earlier lag,
// and if no lag qualifies the result is min_lag. Write min_lag and max_lag
// only while no frame is in flight.
// ----------------------------------------------------------------------------
module open_loop_pitch_search
  import olps_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample beats
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last,
  // result beats
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [LAG_W-1:0]              pitch_lag,
  // register writes
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [LAG_W-1:0]              cfg_data
);

  logic [LAG_W-1:0] min_lag;
  logic [LAG_W-1:0] max_lag;
  logic             q_valid;
  olps_beat_t       q_beat;
  logic             q_pop;

  // search range registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_lag <= MIN_LAG_RESET;
      max_lag <= MAX_LAG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_LAG: min_lag <= cfg_data;
        REG_MAX_LAG: max_lag <= cfg_data;
      endcase
    end
  end

  // front: accept and queue sample beats
  olps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample   (sample),
    .last     (last),
    .q_valid  (q_valid),
    .q_beat   (q_beat),
    .q_pop    (q_pop)
  );

  // back: store the frame, search lags, hold the result beat
  olps_back #(.MAX_FRAME(MAX_FRAME)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_beat    (q_beat),
    .q_pop     (q_pop),
    .min_lag   (min_lag),
    .max_lag   (max_lag),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pitch_lag (pitch_lag)
  );

endmodule

>>> rtl/olps_front.sv
// ----------------------------------------------------------------------------
// olps_front: input side of the pitch search
// Accepts sample beats, tags frame ends, and buffers them in a short queue
// so input can keep flowing while the search engine is busy.
// ----------------------------------------------------------------------------
module olps_front
  import olps_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last,
  output logic                          q_valid,
  output olps_beat_t                    q_beat,
  input  logic                          q_pop
);

  localparam int QA_W = $clog2(QUEUE_DEPTH);

  olps_beat_t      queue [QUEUE_DEPTH];
  logic [QA_W:0]   wr_ptr;
  logic [QA_W:0]   rd_ptr;
  logic            full;
  logic            push;
  olps_beat_t      beat_in;

  assign full     = (wr_ptr[QA_W] != rd_ptr[QA_W]) &&
                    (wr_ptr[QA_W-1:0] == rd_ptr[QA_W-1:0]);
  assign in_stall = full;
  assign push     = in_valid && !full;
  assign q_valid  = (wr_ptr != rd_ptr);
  assign q_beat   = queue[rd_ptr[QA_W-1:0]];

  // classify: a beat carries the sample and whether it closes the frame
  always_comb begin
    beat_in.sample = sample;
    beat_in.last   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr[QA_W-1:0]] <= beat_in;
    end
  end

endmodule

>>> rtl/olps_mul.sv
// ----------------------------------------------------------------------------
// olps_mul: serial shift-add multiplier
// One multiplier bit per cycle; a half-length run serves operands that fit
// in the lower half, leaving the product shifted up by W/2 bits.
// ----------------------------------------------------------------------------
module olps_mul #(
  parameter int W = 80
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           half,
  input  logic [W-1:0]   mcand,
  input  logic [W-1:0]   mplier,
  output logic           busy,
  output logic [2*W-1:0] prod
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]   a;
  logic [2*W-1:0] acc;
  logic [CW-1:0]  cnt;
  logic [W:0]     sum;

  assign sum  = {1'b0, acc[2*W-1:W]} + (acc[0] ? {1'b0, a} : {(W+1){1'b0}});
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= half ? CW'(W / 2) : CW'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a   <= mcand;
      acc <= {{W{1'b0}}, mplier};
    end else if (busy) begin
      acc <= {sum, acc[W-1:1]};
    end
  end

endmodule

>>> rtl/olps_back.sv
// ----------------------------------------------------------------------------
// olps_back: frame store and lag search engine
// Drains the queue into the sample store, then for each lag accumulates the
// cross and energy terms and ranks the lag by exact cross-multiplication.
// ----------------------------------------------------------------------------
module olps_back
  import olps_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  olps_beat_t       q_beat,
  output logic             q_pop,
  input  logic [LAG_W-1:0] min_lag,
  input  logic [LAG_W-1:0] max_lag,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LAG_W-1:0] pitch_lag
);

  localparam int AW    = $clog2(MAX_FRAME);
  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int E_W   = 2 * SAMPLE_BITS - 1 + $clog2(MAX_FRAME);
  localparam int X_W   = E_W + 1;
  localparam int PW    = 2 * E_W;
  localparam int LC_W  = LAG_W + 1;
  localparam int CMP_W = (CNT_W > LC_W) ? CNT_W : LC_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LAG    = 9'b000000010,
    S_MAC    = 9'b000000100,
    S_DRAIN  = 9'b000001000,
    S_CHECK  = 9'b000010000,
    S_SQ     = 9'b000100000,
    S_CROSS  = 9'b001000000,
    S_NEXT   = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t                          state;
  logic signed [SAMPLE_BITS-1:0]   store [MAX_FRAME];
  logic [CNT_W-1:0]                count;
  logic [CNT_W-1:0]                count_inc;
  logic [CNT_W-1:0]                len;
  logic [CNT_W-1:0]                len_new;
  logic [CNT_W-1:0]                seg;
  logic [CNT_W-1:0]                i;
  logic [LC_W-1:0]                 lag;
  logic [CMP_W-1:0]                seg_full;
  logic [CMP_W-1:0]                b_full;
  logic                            room;
  logic                            frame_end;
  logic                            lag_ok;
  logic                            mac_last;
  logic                            rd_en;
  logic                            v1;
  logic                            v2;
  logic signed [SAMPLE_BITS-1:0]   rd_a;
  logic signed [SAMPLE_BITS-1:0]   rd_b;
  logic signed [2*SAMPLE_BITS-1:0] p_xy;
  logic signed [2*SAMPLE_BITS-1:0] p_xx;
  logic signed [2*SAMPLE_BITS-1:0] p_yy;
  logic signed [X_W-1:0]           xy;
  logic [E_W-1:0]                  xx;
  logic [E_W-1:0]                  yy;
  logic [X_W-1:0]                  xy_abs;
  logic [E_W-1:0]                  xy_mag;
  logic                            cand_neg;
  logic                            best_neg;
  logic                            sign_diff;
  logic                            chk_skip;
  logic                            start_sq;
  logic                            start_cross;
  logic                            sq_fin;
  logic                            sq_take;
  logic                            cross_fin;
  logic                            cross_win;
  logic                            take;
  logic                            fin_load;
  logic                            have_best;
  logic [LAG_W-1:0]                held_lag;
  logic signed [X_W-1:0]           best_cross;
  logic [PW-1:0]                   best_sq;
  logic [PW-1:0]                   best_ee;
  logic [PW-1:0]                   sq_c;
  logic [PW-1:0]                   ee_c;
  logic [PW-1:0]                   sq_val;
  logic [PW-1:0]                   ee_val;
  logic [PW-1:0]                   take_sq;
  logic [PW-1:0]                   take_ee;
  logic                            m_start;
  logic [PW-1:0]                   m0_a;
  logic [PW-1:0]                   m0_b;
  logic [PW-1:0]                   m1_a;
  logic [PW-1:0]                   m1_b;
  logic                            m0_busy;
  logic                            m1_busy;
  logic [2*PW-1:0]                 m0_prod;
  logic [2*PW-1:0]                 m1_prod;

  // frame loading
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign room      = (count < CNT_W'(MAX_FRAME));
  assign count_inc = count + CNT_W'(1);
  assign len_new   = room ? count_inc : count;
  assign frame_end = q_pop && q_beat.last;

  // lag walk and accumulation addressing
  assign lag_ok   = (CMP_W'(lag) <= CMP_W'(max_lag)) && (CMP_W'(lag) < CMP_W'(len));
  assign seg_full = CMP_W'(len) - CMP_W'(lag);
  assign b_full   = CMP_W'(i) + CMP_W'(lag);
  assign mac_last = (i == seg - CNT_W'(1));
  assign rd_en    = (state == S_MAC);

  // ranking
  assign cand_neg  = xy[X_W-1];
  assign best_neg  = best_cross[X_W-1];
  assign sign_diff = (cand_neg != best_neg);
  assign xy_abs    = cand_neg ? $unsigned(-xy) : $unsigned(xy);
  assign xy_mag    = xy_abs[E_W-1:0];
  assign chk_skip  = (xx == '0) || (yy == '0) || (have_best && sign_diff && !best_neg);

  assign start_sq    = (state == S_CHECK) && !chk_skip;
  assign sq_val      = m0_prod[PW+E_W-1:E_W];
  assign ee_val      = m1_prod[PW+E_W-1:E_W];
  assign sq_fin      = (state == S_SQ) && !m0_busy;
  assign sq_take     = sq_fin && (!have_best || sign_diff);
  assign start_cross = sq_fin && !sq_take;
  assign cross_fin   = (state == S_CROSS) && !m0_busy;
  assign cross_win   = cand_neg ? (m0_prod < m1_prod) : (m0_prod > m1_prod);
  assign take        = sq_take || (cross_fin && cross_win);
  assign take_sq     = (state == S_SQ) ? sq_val : sq_c;
  assign take_ee     = (state == S_SQ) ? ee_val : ee_c;

  // unit 0: |xy|^2, then |xy|^2 * best energy product
  // unit 1: xx * yy, then best |xy|^2 * candidate energy product
  assign m_start = start_sq || start_cross;
  assign m0_a    = start_sq ? PW'(xy_mag) : sq_val;
  assign m0_b    = start_sq ? PW'(xy_mag) : best_ee;
  assign m1_a    = start_sq ? PW'(xx) : best_sq;
  assign m1_b    = start_sq ? PW'(yy) : ee_val;

  assign fin_load = (state == S_FINISH) && (!out_valid || !out_stall);

  olps_mul #(.W(PW)) u_mul0 (
    .clk    (clk),
    .rst    (rst),
    .start  (m_start),
    .half   (start_sq),
    .mcand  (m0_a),
    .mplier (m0_b),
    .busy   (m0_busy),
    .prod   (m0_prod)
  );

  olps_mul #(.W(PW)) u_mul1 (
    .clk    (clk),
    .rst    (rst),
    .start  (m_start),
    .half   (start_sq),
    .mcand  (m1_a),
    .mplier (m1_b),
    .busy   (m1_busy),
    .prod   (m1_prod)
  );

  // sample store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (q_pop && room) begin
      store[count[AW-1:0]] <= q_beat.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= store[i[AW-1:0]];
      rd_b <= store[b_full[AW-1:0]];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      have_best <= 1'b0;
      out_valid <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        have_best <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_beat.last) begin
              count     <= '0;
              have_best <= 1'b0;
              state     <= S_LAG;
            end else if (room) begin
              count <= count_inc;
            end
          end
        end
        S_LAG: begin
          state <= lag_ok ? S_MAC : S_FINISH;
        end
        S_MAC: begin
          if (mac_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= chk_skip ? S_NEXT : S_SQ;
        end
        S_SQ: begin
          if (!m0_busy) begin
            state <= sq_take ? S_NEXT : S_CROSS;
          end
        end
        S_CROSS: begin
          if (!m0_busy) begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          state <= S_LAG;
        end
        S_FINISH: begin
          if (fin_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p_xy <= rd_a * rd_b;
    p_xx <= rd_a * rd_a;
    p_yy <= rd_b * rd_b;

    if (state == S_LAG) begin
      xy <= '0;
      xx <= '0;
      yy <= '0;
    end else if (v2) begin
      xy <= xy + X_W'(p_xy);
      xx <= xx + E_W'($unsigned(p_xx));
      yy <= yy + E_W'($unsigned(p_yy));
    end

    if (frame_end) begin
      len      <= len_new;
      lag      <= LC_W'(min_lag);
      held_lag <= min_lag;
    end
    if (state == S_LAG) begin
      seg <= seg_full[CNT_W-1:0];
      i   <= '0;
    end
    if (state == S_MAC) begin
      i <= i + CNT_W'(1);
    end
    if (state == S_NEXT) begin
      lag <= lag + LC_W'(1);
    end
    if (sq_fin) begin
      sq_c <= sq_val;
      ee_c <= ee_val;
    end
    if (take) begin
      held_lag   <= lag[LAG_W-1:0];
      best_cross <= xy;
      best_sq    <= take_sq;
      best_ee    <= take_ee;
    end
    if (fin_load) begin
      pitch_lag <= held_lag;
    end
  end

  // both units are started together and must finish together
  a_mul_lockstep: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ || state == S_CROSS) |-> (m0_busy == m1_busy))
    else $error("olps_back: multiplier units out of step");

  // the lagged read never reaches past the loaded frame
  a_read_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC) |-> (CMP_W'(CMP_W'(i) + CMP_W'(lag)) < CMP_W'(len)))
    else $error("olps_back: lagged read beyond frame");

  // ranking only starts once the accumulation pipeline is empty
  a_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (!v1 && !v2))
    else $error("olps_back: ranking with accumulation in flight");

  // a chosen lag always lies inside the searched range
  a_lag_range: assert property (@(posedge clk) disable iff (rst)
    (fin_load && have_best) |-> (held_lag >= min_lag && held_lag <= max_lag))
    else $error("olps_back: chosen lag outside search range");

endmodule
